@@ rtl/core/sfcbr_pkg.sv @@
// Shared types, codes and constants for the sfc32 bounded random core.
package sfcbr_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned SHIFT_A = 9;
  localparam int unsigned SHIFT_B = 3;
  localparam int unsigned ROT_C   = 21;
  localparam int unsigned CNT_W   = $clog2(DATA_W + 1);

  // Request opcodes
  localparam logic [1:0] OP_RAW     = 2'd0;
  localparam logic [1:0] OP_BOUNDED = 2'd1;
  localparam logic [1:0] OP_RESEED  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SEED_A = 2'd0;
  localparam logic [1:0] CFG_SEED_B = 2'd1;
  localparam logic [1:0] CFG_SEED_C = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW,
    ST_MOD,
    ST_CHECK,
    ST_FINISH
  } sfcbr_state_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } sfcbr_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] remainder;
  } sfcbr_div_rsp_t;

endpackage

@@ rtl/core/sfc32_bounded_random_core.sv @@
// Top level: sfc32 generator with raw, unbiased bounded and reseed requests.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  req     | req_valid, req_ready, op, lower_bound,       | in
//          | upper_bound                                  |
//  rsp     | rsp_valid, rsp_ready, value, range_empty     | out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data    | in
//
// Raw draw: transfer, draw state, then finish state and result register. Reseed, unused op
// and empty range go straight to the finish state. Bounded draw: per attempt a draw state,
// a wait on the 32-step radix-2 remainder unit, and a check state; a rejected draw repeats
// the attempt. The core passes back through the idle state before the next transfer.
// rst is synchronous: generator words clear, draw counter goes to 1, seeds
// clear. The core takes one request at a time; req_ready is high only when
// idle. A result waits in the finish state while the output register still
// holds an untaken transfer. cfg_ready is always high.
module sfc32_bounded_random_core (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [1:0]                    op,
  input  logic [sfcbr_pkg::DATA_W-1:0]  lower_bound,
  input  logic [sfcbr_pkg::DATA_W-1:0]  upper_bound,
  // response channel
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [sfcbr_pkg::DATA_W-1:0]  value,
  output logic                          range_empty,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [sfcbr_pkg::DATA_W-1:0]  cfg_data
);

  localparam int unsigned W = sfcbr_pkg::DATA_W;

  sfcbr_pkg::sfcbr_state_t   state, state_next;
  sfcbr_pkg::sfcbr_div_req_t div_req;
  sfcbr_pkg::sfcbr_div_rsp_t div_rsp;

  // seed registers
  logic [W-1:0] seed_a, seed_b, seed_c;
  // generator state
  logic [W-1:0] word_a, word_b, word_c, draw_counter;
  // request context
  logic         bounded;
  logic [W-1:0] lo;
  logic [W-1:0] range;
  logic [W-1:0] draw;
  // finished result waiting for the output register
  logic [W-1:0] res_value;
  logic         res_empty;

  logic         req_xfer;
  logic         out_free;
  logic [W-1:0] draw_sum;
  logic [W-1:0] req_range;
  logic         reject;

  assign req_xfer  = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;
  assign cfg_ready = 1'b1;
  assign req_range = upper_bound - lower_bound;
  assign draw_sum  = word_a + word_b + draw_counter;
  // Reject when x - r lands above 2^32 - range: the partial last bucket.
  assign reject    = (draw - div_rsp.remainder) > (W'(0) - range);

  assign div_req.start    = (state == sfcbr_pkg::ST_DRAW) && bounded;
  assign div_req.dividend = draw_sum;
  assign div_req.divisor  = range;

  sfcbr_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    unique case (state)
      sfcbr_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (op == sfcbr_pkg::OP_RAW ||
              (op == sfcbr_pkg::OP_BOUNDED && req_range != '0)) begin
            state_next = sfcbr_pkg::ST_DRAW;
          end else begin
            state_next = sfcbr_pkg::ST_FINISH;
          end
        end
      end
      sfcbr_pkg::ST_DRAW: begin
        state_next = bounded ? sfcbr_pkg::ST_MOD : sfcbr_pkg::ST_FINISH;
      end
      sfcbr_pkg::ST_MOD: begin
        if (div_rsp.done) begin
          state_next = sfcbr_pkg::ST_CHECK;
        end
      end
      sfcbr_pkg::ST_CHECK: begin
        state_next = reject ? sfcbr_pkg::ST_DRAW : sfcbr_pkg::ST_FINISH;
      end
      sfcbr_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = sfcbr_pkg::ST_IDLE;
        end
      end
      default: state_next = sfcbr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfcbr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Seed registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_a <= '0;
      seed_b <= '0;
      seed_c <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sfcbr_pkg::CFG_SEED_A: seed_a <= cfg_data;
        sfcbr_pkg::CFG_SEED_B: seed_b <= cfg_data;
        sfcbr_pkg::CFG_SEED_C: seed_c <= cfg_data;
        default: ;
      endcase
    end
  end

  // Generator step and reseed
  always_ff @(posedge clk) begin
    if (rst) begin
      word_a       <= '0;
      word_b       <= '0;
      word_c       <= '0;
      draw_counter <= W'(1);
    end else if (req_xfer && op == sfcbr_pkg::OP_RESEED) begin
      word_a       <= seed_a;
      word_b       <= seed_b;
      word_c       <= seed_c;
      draw_counter <= W'(1);
    end else if (state == sfcbr_pkg::ST_DRAW) begin
      word_a       <= word_b ^ (word_b >> sfcbr_pkg::SHIFT_A);
      word_b       <= word_c + (word_c << sfcbr_pkg::SHIFT_B);
      word_c       <= ((word_c << sfcbr_pkg::ROT_C) |
                       (word_c >> (W - sfcbr_pkg::ROT_C))) + draw_sum;
      draw_counter <= draw_counter + W'(1);
    end
  end

  // Request context and result
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      bounded   <= (op == sfcbr_pkg::OP_BOUNDED);
      lo        <= lower_bound;
      range     <= req_range;
      // empty range, reseed and unused op finish straight away
      res_empty <= (op == sfcbr_pkg::OP_BOUNDED) && (req_range == '0);
      res_value <= (op == sfcbr_pkg::OP_BOUNDED) ? lower_bound : '0;
    end else if (state == sfcbr_pkg::ST_DRAW) begin
      draw      <= draw_sum;
      res_value <= draw_sum;
    end else if (state == sfcbr_pkg::ST_CHECK) begin
      res_value <= div_rsp.remainder + lo;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == sfcbr_pkg::ST_FINISH && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sfcbr_pkg::ST_FINISH && out_free) begin
      value       <= res_value;
      range_empty <= res_empty;
    end
  end

  // Checks
  a_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == sfcbr_pkg::ST_MOD)
    else $error("remainder unit finished outside the wait state");

  a_rem_below_range: assert property (@(posedge clk) disable iff (rst)
    state == sfcbr_pkg::ST_CHECK |-> div_rsp.remainder < range)
    else $error("remainder not below range");

  a_counter_hold: assert property (@(posedge clk) disable iff (rst)
    (state != sfcbr_pkg::ST_DRAW && !(req_xfer && op == sfcbr_pkg::OP_RESEED))
      |=> $stable(draw_counter))
    else $error("draw counter moved without a draw or reseed");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> !req_ready)
    else $error("request taken while previous one still in work");

endmodule

@@ rtl/core/sfcbr_mod_unit.sv @@
// Iterative radix-2 restoring remainder unit, one quotient bit per cycle.
module sfcbr_mod_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  sfcbr_pkg::sfcbr_div_req_t req,
  output sfcbr_pkg::sfcbr_div_rsp_t rsp
);

  logic                            active;
  logic                            done;
  logic [sfcbr_pkg::CNT_W-1:0]     count;
  logic [sfcbr_pkg::DATA_W-1:0]    shifter;
  logic [sfcbr_pkg::DATA_W-1:0]    divisor;
  logic [sfcbr_pkg::DATA_W:0]      rem;
  logic [sfcbr_pkg::DATA_W:0]      trial;
  logic [sfcbr_pkg::DATA_W:0]      rem_next;

  // Shift in the next dividend bit, subtract when it fits.
  always_comb begin
    trial = {rem[sfcbr_pkg::DATA_W-1:0], shifter[sfcbr_pkg::DATA_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = trial - {1'b0, divisor};
    end else begin
      rem_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        count  <= sfcbr_pkg::CNT_W'(sfcbr_pkg::DATA_W);
      end else if (active) begin
        count <= count - 1'b1;
        if (count == sfcbr_pkg::CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      shifter <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (active) begin
      shifter <= {shifter[sfcbr_pkg::DATA_W-2:0], 1'b0};
      rem     <= rem_next;
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem[sfcbr_pkg::DATA_W-1:0];

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the sfc32 bounded random core: directed and random draws.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned DATA_W = sfcbr_pkg::DATA_W;

  // Op code 3 has no package name; the core ignores it but must still answer
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Cycles with no transfer on any channel before the run is declared hung.
  // Worst honest stretch: a bounded draw near 2^31 range rejects about half
  // its attempts, each waiting on the remainder unit, plus the longest receiver
  // stall and sender gap; the limit leaves hundreds of attempts of margin.
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 8;   // slowest non-bounded op is a raw draw
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic [1:0]        op;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    bit                settle;   // hold this item until all results are back
  } draw_req_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              empty;
  } draw_rsp_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_SPOTTY,
    READY_LONG_STALLS
  } ready_mode_t;

  // ---------------------------------------------------------------------
  // DUT signals; every input is known from time zero
  // ---------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  logic [1:0]        op = sfcbr_pkg::OP_RAW;
  logic [DATA_W-1:0] lower_bound = '0;
  logic [DATA_W-1:0] upper_bound = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  logic [DATA_W-1:0] value;
  logic              range_empty;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = sfcbr_pkg::CFG_SEED_A;
  logic [DATA_W-1:0] cfg_data = '0;

  sfc32_bounded_random_core u_top (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .op          (op),
    .lower_bound (lower_bound),
    .upper_bound (upper_bound),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .value       (value),
    .range_empty (range_empty),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Generator model: our own copy of the words, counter and seed registers
  // ---------------------------------------------------------------------
  logic [DATA_W-1:0] gen_a = '0;
  logic [DATA_W-1:0] gen_b = '0;
  logic [DATA_W-1:0] gen_c = '0;
  logic [DATA_W-1:0] gen_count = 32'd1;
  logic [DATA_W-1:0] seed_a = '0;
  logic [DATA_W-1:0] seed_b = '0;
  logic [DATA_W-1:0] seed_c = '0;

  draw_req_t pending_reqs[$];     // stimulus not yet offered to the core
  draw_rsp_t expected_draws[$];   // predicted results, oldest first

  logic        req_taken = 1'b0;  // transfer seen at the last rising edge
  logic        cfg_taken = 1'b0;
  int unsigned bad_count = 0;
  int unsigned quiet_cycles = 0;

  // One generator step: output is a + b + counter, then the words scramble
  function automatic logic [DATA_W-1:0] sfc_advance();
    logic [DATA_W-1:0] draw;
    draw      = gen_a + gen_b + gen_count;
    gen_a     = gen_b ^ (gen_b >> sfcbr_pkg::SHIFT_A);
    gen_b     = gen_c + (gen_c << sfcbr_pkg::SHIFT_B);
    gen_c     = ((gen_c << sfcbr_pkg::ROT_C) |
                 (gen_c >> (DATA_W - sfcbr_pkg::ROT_C))) + draw;
    gen_count = gen_count + 1'b1;
    return draw;
  endfunction

  // Expected result of one accepted request; advances the model state
  function automatic draw_rsp_t predict_draw(input logic [1:0] code,
                                             input logic [DATA_W-1:0] lo,
                                             input logic [DATA_W-1:0] hi);
    draw_rsp_t         res;
    logic [DATA_W-1:0] span;
    logic [DATA_W-1:0] lim;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] rem;
    res.value = '0;
    res.empty = 1'b0;
    case (code)
      sfcbr_pkg::OP_RAW: begin
        res.value = sfc_advance();
      end
      sfcbr_pkg::OP_BOUNDED: begin
        span = hi - lo;                 // wraps mod 2^32
        if (span == '0) begin
          // empty range: echo lo, flag it, leave the generator alone
          res.value = lo;
          res.empty = 1'b1;
        end else begin
          lim = '0 - span;
          // reject draws from the short last bucket to keep it unbiased
          do begin
            x   = sfc_advance();
            rem = x % span;
          end while ((x - rem) > lim);
          res.value = rem + lo;
        end
      end
      sfcbr_pkg::OP_RESEED: begin
        gen_a     = seed_a;
        gen_b     = seed_b;
        gen_c     = seed_c;
        gen_count = 32'd1;
      end
      default: ;                        // unused code: no state change
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Monitor and predictor: everything sampled at the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      gen_a     = '0;
      gen_b     = '0;
      gen_c     = '0;
      gen_count = 32'd1;
      seed_a    = '0;
      seed_b    = '0;
      seed_c    = '0;
      req_taken <= 1'b0;
      cfg_taken <= 1'b0;
      quiet_cycles = 0;
    end else begin
      req_taken <= req_valid && req_ready;
      cfg_taken <= cfg_valid && cfg_ready;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sfcbr_pkg::CFG_SEED_A: seed_a = cfg_data;
          sfcbr_pkg::CFG_SEED_B: seed_b = cfg_data;
          sfcbr_pkg::CFG_SEED_C: seed_c = cfg_data;
          default: ;
        endcase
      end

      if (req_valid && req_ready)
        expected_draws.push_back(predict_draw(op, lower_bound, upper_bound));

      if (rsp_valid && rsp_ready) begin
        if (expected_draws.size() == 0) begin
          bad_count++;
          if (bad_count <= MAX_REPORTS)
            $display("ERROR %0t: unexpected result value=%h range_empty=%b",
                     $realtime, value, range_empty);
        end else begin
          draw_rsp_t want;
          want = expected_draws.pop_front();
          if (value !== want.value || range_empty !== want.empty) begin
            bad_count++;
            if (bad_count <= MAX_REPORTS)
              $display("ERROR %0t: value exp %h got %h, range_empty exp %b got %b",
                       $realtime, want.value, value, want.empty, range_empty);
          end
        end
      end

      // watchdog: any transfer on any channel counts as progress
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("sfc32_bounded_random_core test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request driver: bursts of back-to-back items with random gaps.
  // Valid is computed once per falling edge so it gets a single update.
  // ---------------------------------------------------------------------
  draw_req_t   cur_req;
  logic        on_bus;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      on_bus = req_valid && !req_taken;
      if (!on_bus) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].settle && expected_draws.size() != 0)) begin
          cur_req = pending_reqs.pop_front();
          op          <= cur_req.op;
          lower_bound <= cur_req.lo;
          upper_bound <= cur_req.hi;
          on_bus = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
          end
        end
      end
      req_valid <= on_bus;
    end
  end

  // ---------------------------------------------------------------------
  // Response backpressure: the mode is redrawn at random among always
  // ready, ready dropped on random cycles, and long stalls.
  // ---------------------------------------------------------------------
  ready_mode_t ready_mode = READY_ALWAYS;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 2));
      mode_left  = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      READY_ALWAYS: rsp_ready <= 1'b1;
      READY_SPOTTY: rsp_ready <= ($urandom_range(0, 9) < 7);
      default: begin
        if (hold_left > 0) begin
          hold_left--;
          rsp_ready <= 1'b0;
        end else begin
          rsp_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0)
            hold_left = $urandom_range(1, 40);
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic void add_req(input logic [1:0] code, input logic [DATA_W-1:0] lo,
                                  input logic [DATA_W-1:0] hi, input bit settle);
    draw_req_t r;
    r.op     = code;
    r.lo     = lo;
    r.hi     = hi;
    r.settle = settle;
    pending_reqs.push_back(r);
  endfunction

  // Range mix: tiny, powers of two, around 2^31 (heavy rejection), near
  // full width, fully random, and empty
  function automatic draw_req_t random_req();
    draw_req_t         r;
    logic [DATA_W-1:0] span;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 44)      r.op = sfcbr_pkg::OP_RAW;
    else if (pick < 90) r.op = sfcbr_pkg::OP_BOUNDED;
    else if (pick < 96) r.op = sfcbr_pkg::OP_RESEED;
    else                r.op = OP_UNUSED;

    pick = $urandom_range(0, 99);
    if (pick < 15)      r.lo = '0;
    else if (pick < 25) r.lo = '1;
    else                r.lo = $urandom;

    pick = $urandom_range(0, 99);
    if (pick < 30)      span = $urandom_range(1, 16);
    else if (pick < 55) span = $urandom;
    else if (pick < 70) span = 32'd1 << $urandom_range(0, 31);
    else if (pick < 80) span = 32'h8000_0000 + $urandom_range(0, 64) - 32;
    else if (pick < 90) span = 32'hFFFF_FFFF - $urandom_range(0, 64);
    else                span = '0;
    r.hi = r.lo + span;

    // fields the op ignores still get random bits
    if (r.op != sfcbr_pkg::OP_BOUNDED && $urandom_range(0, 1) == 1)
      r.hi = $urandom;
    r.settle = ($urandom_range(0, 99) == 0);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_seed();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  task automatic write_seed(input logic [1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_seeds(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                             input logic [DATA_W-1:0] c);
    write_seed(sfcbr_pkg::CFG_SEED_A, a);
    write_seed(sfcbr_pkg::CFG_SEED_B, b);
    write_seed(sfcbr_pkg::CFG_SEED_C, c);
  endtask

  // Everything offered, accepted and answered; then let the core go idle
  task automatic wait_drained(input int unsigned extra);
    do @(posedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_draws.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, seeds at reset value zero
    add_req(sfcbr_pkg::OP_RAW,     '0,            '0,            1'b0);
    add_req(sfcbr_pkg::OP_RAW,     '0,            '0,            1'b0);
    add_req(sfcbr_pkg::OP_BOUNDED, '0,            '0,            1'b0);  // empty range
    add_req(sfcbr_pkg::OP_BOUNDED, '1,            '1,            1'b0);  // empty at the top
    add_req(sfcbr_pkg::OP_BOUNDED, '0,            32'd1,         1'b0);  // range of one
    add_req(sfcbr_pkg::OP_BOUNDED, '0,            '1,            1'b0);
    add_req(sfcbr_pkg::OP_BOUNDED, '1,            '0,            1'b0);  // wraps, range one
    add_req(sfcbr_pkg::OP_BOUNDED, 32'd10,        32'd5,         1'b0);  // wraps, huge range
    add_req(sfcbr_pkg::OP_BOUNDED, 32'h8000_0000, '0,            1'b0);  // range 2^31
    add_req(sfcbr_pkg::OP_BOUNDED, '0,            32'h8000_0001, 1'b0);  // worst rejection
    add_req(sfcbr_pkg::OP_BOUNDED, 32'd1,         '0,            1'b0);  // range 2^32 - 1
    add_req(OP_UNUSED,             '1,            '1,            1'b0);
    add_req(OP_UNUSED,             '0,            '0,            1'b0);
    add_req(sfcbr_pkg::OP_RESEED,  '0,            '0,            1'b1);  // sender waits first
    add_req(sfcbr_pkg::OP_RAW,     '0,            '0,            1'b0);
    add_req(sfcbr_pkg::OP_RAW,     '1,            '1,            1'b0);
    wait_drained(SETTLE_CYCLES);

    // Directed, seeds all ones
    write_seeds('1, '1, '1);
    add_req(sfcbr_pkg::OP_RESEED,  '0,            '0,            1'b0);
    add_req(sfcbr_pkg::OP_RAW,     '0,            '0,            1'b0);
    add_req(sfcbr_pkg::OP_RAW,     '0,            '0,            1'b0);
    add_req(sfcbr_pkg::OP_BOUNDED, '0,            32'd7,         1'b0);
    add_req(sfcbr_pkg::OP_BOUNDED, 32'hFFFF_FFF0, '1,            1'b0);
    add_req(OP_UNUSED,             32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    wait_drained(SETTLE_CYCLES);

    // Random phases, each under a fresh set of seeds; a reseed leads each
    // phase so the new seeds get exercised right away
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_seeds(pick_seed(), pick_seed(), pick_seed());
      add_req(sfcbr_pkg::OP_RESEED, $urandom, $urandom, 1'b0);
      for (int i = 1; i < PHASE_ITEMS; i++)
        pending_reqs.push_back(random_req());
      wait_drained(SETTLE_CYCLES);
    end

    wait_drained(TAIL_CYCLES);
    if (bad_count == 0 && expected_draws.size() == 0)
      $display("sfc32_bounded_random_core test passed");
    else
      $display("sfc32_bounded_random_core test failed");
    $finish;
  end

endmodule
